>>> rtl/core/masked_pixel_statistics_core_assert.svh
// assertion macros for the masked pixel statistics core
// no dependencies; included by modules that carry concurrent checks
`ifndef MASKED_PIXEL_STATISTICS_CORE_ASSERT_SVH
`define MASKED_PIXEL_STATISTICS_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/mps_pkg.sv
// shared types and constants of the masked pixel statistics core
// no dependencies
`default_nettype none
package mps_pkg;

    localparam int MAX_PIXELS_LOG2_DEF = 24;

    // pixel classes decided in the front part
    localparam logic [1:0] K_FLAGGED  = 2'd0;
    localparam logic [1:0] K_BAD_ERR  = 2'd1;
    localparam logic [1:0] K_USE_ZERO = 2'd2;
    localparam logic [1:0] K_USE_DIV  = 2'd3;

    // frame status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ALL_BAD  = 2'd1;
    localparam logic [1:0] ST_MIXED    = 2'd2;
    localparam logic [1:0] ST_FLAGGED  = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic               last;
        logic signed [31:0] sci;
        logic signed [31:0] err;
    } t_pix;

endpackage
`default_nettype wire

>>> rtl/core/mps_front.sv
// front part: mask register, pixel classification and pixel queue
// depends on mps_pkg
`default_nettype none
module mps_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [15:0]  i_cfg_data,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [79:0]  i_s_tdata,  // sci_value, err_value, quality_flags
    input  wire logic         i_s_tlast,  // last_pixel
    output logic              o_q_valid,
    output mps_pkg::t_pix     o_q_item,
    input  wire logic         i_q_pop
);
    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    logic [15:0]    r_mask;
    mps_pkg::t_pix  r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [PW:0]    r_count, n_count;
    mps_pkg::t_pix  pix;
    logic signed [31:0] sci, err;
    logic [15:0]    flags;
    logic           push;

    assign o_cfg_ready = 1'b1;
    assign sci   = i_s_tdata[31:0];
    assign err   = i_s_tdata[63:32];
    assign flags = i_s_tdata[79:64];

    always_comb begin
        pix.sci  = sci;
        pix.err  = err;
        pix.last = i_s_tlast;
        if ((flags & r_mask) != 16'h0) begin
            pix.kind = mps_pkg::K_FLAGGED;
        end else if (err <= 32'sd0) begin
            pix.kind = (sci <= 32'sd0) ? mps_pkg::K_USE_ZERO : mps_pkg::K_BAD_ERR;
        end else begin
            pix.kind = mps_pkg::K_USE_DIV;
        end
    end

    assign o_s_tready = (r_count != (PW+1)'(DEPTH));
    assign push       = i_s_tvalid && o_s_tready;
    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (push && !i_q_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_q_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_mask <= i_cfg_data;
            end
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= pix;
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/mps_divider.sv
// shared iterative signed divider, one quotient bit per cycle, saturated to 32 bits
// no dependencies; divisor is always positive
`default_nettype none
module mps_divider #(
    parameter int DW = 56,
    parameter int VW = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [DW-1:0] i_dividend,
    input  wire logic [VW-1:0]        i_divisor,
    output logic                      o_done,
    output logic signed [31:0]        o_quot
);
    localparam int CW = $clog2(DW + 1);

    logic          r_busy, r_done, r_neg;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quo;
    logic [VW:0]   r_rem;
    logic [VW-1:0] r_div;
    logic [VW:0]   rem_sh;
    logic          fits;

    assign rem_sh = {r_rem[VW-1:0], r_quo[DW-1]};
    assign fits   = (rem_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[DW-1];
            r_quo <= i_dividend[DW-1] ? (-i_dividend) : i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
            r_cnt <= CW'(DW);
        end else if (r_busy) begin
            r_rem <= fits ? (rem_sh - {1'b0, r_div}) : rem_sh;
            r_quo <= {r_quo[DW-2:0], fits};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_comb begin
        if (!r_neg) begin
            o_quot = (r_quo[DW-1:31] != '0) ? 32'sh7FFF_FFFF : $signed(r_quo[31:0]);
        end else if ((r_quo[DW-1:32] != '0) || (r_quo[31] && (r_quo[30:0] != '0))) begin
            o_quot = 32'sh8000_0000;
        end else begin
            o_quot = -$signed(r_quo[31:0]);
        end
    end

    assign o_done = r_done;
endmodule
`default_nettype wire

>>> rtl/core/mps_back.sv
// back part: accumulators, end-of-frame means, status and result register
// depends on mps_pkg and masked_pixel_statistics_core_assert.svh, drives the shared mps_divider
`default_nettype none
`include "masked_pixel_statistics_core_assert.svh"
module mps_back #(
    parameter int CNT_W = 25,
    parameter int SUM_W = 56,
    parameter int DW    = 56,
    parameter int VW    = 32,
    parameter int OUT_W = 320
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_valid,
    input  wire mps_pkg::t_pix        i_q_item,
    output logic                      o_q_pop,
    output logic                      o_div_start,
    output logic signed [DW-1:0]      o_div_dividend,
    output logic [VW-1:0]             o_div_divisor,
    input  wire logic                 i_div_done,
    input  wire logic signed [31:0]   i_div_quot,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [OUT_W-1:0]          o_m_tdata
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SNR    = 3'd1;
    localparam logic [2:0] S_MSTART = 3'd2;
    localparam logic [2:0] S_MWAIT  = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [1:0]             r_k, n_k;
    logic [CNT_W-1:0]       r_good, n_good, r_bad, n_bad, r_pix, n_pix;
    logic signed [SUM_W-1:0] r_sum [3];
    logic signed [SUM_W-1:0] n_sum [3];
    logic signed [31:0]     r_min [3];
    logic signed [31:0]     n_min [3];
    logic signed [31:0]     r_max [3];
    logic signed [31:0]     n_max [3];
    logic signed [31:0]     r_mean [3];
    logic signed [31:0]     n_mean [3];
    logic signed [31:0]     r_sci, n_sci, r_err, n_err;
    logic                   r_last, n_last;
    logic                   r_out_valid, n_out_valid;
    logic [OUT_W-1:0]       r_out_data, n_out_data;
    logic                   upd_en;
    logic signed [31:0]     upd_v [3];
    logic signed [47:0]     snr_num;
    logic [1:0]             status;

    assign snr_num = {i_q_item.sci, 16'h0};

    always_comb begin
        if (r_good != '0) begin
            status = mps_pkg::ST_OK;
        end else if (r_bad != '0) begin
            status = (r_bad == r_pix) ? mps_pkg::ST_ALL_BAD : mps_pkg::ST_MIXED;
        end else begin
            status = mps_pkg::ST_FLAGGED;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_good      = r_good;
        n_bad       = r_bad;
        n_pix       = r_pix;
        n_sum       = r_sum;
        n_min       = r_min;
        n_max       = r_max;
        n_mean      = r_mean;
        n_sci       = r_sci;
        n_err       = r_err;
        n_last      = r_last;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !i_m_tready;
        o_q_pop        = 1'b0;
        o_div_start    = 1'b0;
        o_div_dividend = DW'(snr_num);
        o_div_divisor  = VW'($unsigned(i_q_item.err));
        upd_en   = 1'b0;
        upd_v[0] = r_sci;
        upd_v[1] = r_err;
        upd_v[2] = i_div_quot;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_pix   = (r_pix == '1) ? r_pix : r_pix + 1'b1;
                    n_sci   = i_q_item.sci;
                    n_err   = i_q_item.err;
                    n_last  = i_q_item.last;
                    n_k     = 2'd0;
                    n_state = i_q_item.last ? S_MSTART : S_IDLE;
                    unique case (i_q_item.kind)
                        mps_pkg::K_FLAGGED: begin
                        end
                        mps_pkg::K_BAD_ERR: begin
                            n_bad = (r_bad == '1) ? r_bad : r_bad + 1'b1;
                        end
                        mps_pkg::K_USE_ZERO: begin
                            upd_en   = 1'b1;
                            upd_v[0] = i_q_item.sci;
                            upd_v[1] = i_q_item.err;
                            upd_v[2] = 32'sd0;
                        end
                        mps_pkg::K_USE_DIV: begin
                            o_div_start = 1'b1;
                            n_state     = S_SNR;
                        end
                    endcase
                end
            end
            S_SNR: begin
                if (i_div_done) begin
                    upd_en  = 1'b1;
                    n_state = r_last ? S_MSTART : S_IDLE;
                end
            end
            S_MSTART: begin
                if (r_good == '0) begin
                    n_state = S_OUT;
                end else begin
                    o_div_start    = 1'b1;
                    o_div_dividend = DW'(r_sum[r_k]);
                    o_div_divisor  = VW'(r_good);
                    n_state        = S_MWAIT;
                end
            end
            S_MWAIT: begin
                if (i_div_done) begin
                    n_mean[r_k] = i_div_quot;
                    if (r_k == 2'd2) begin
                        n_state = S_OUT;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_MSTART;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    if (r_good == '0) begin
                        n_out_data = OUT_W'(status) << (CNT_W + 288);
                    end else begin
                        n_out_data = OUT_W'({status,
                            r_mean[2], r_max[2], r_min[2],
                            r_mean[1], r_max[1], r_min[1],
                            r_mean[0], r_max[0], r_min[0], r_good});
                    end
                    n_good  = '0;
                    n_bad   = '0;
                    n_pix   = '0;
                    for (int i = 0; i < 3; i++) begin
                        n_sum[i] = '0;
                        n_min[i] = '0;
                        n_max[i] = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (upd_en) begin
            for (int i = 0; i < 3; i++) begin
                if (r_good == '0) begin
                    n_min[i] = upd_v[i];
                    n_max[i] = upd_v[i];
                    n_sum[i] = SUM_W'(upd_v[i]);
                end else begin
                    if (upd_v[i] < r_min[i]) begin
                        n_min[i] = upd_v[i];
                    end
                    if (upd_v[i] > r_max[i]) begin
                        n_max[i] = upd_v[i];
                    end
                    n_sum[i] = r_sum[i] + SUM_W'(upd_v[i]);
                end
            end
            n_good = (r_good == '1) ? r_good : r_good + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_good      <= '0;
            r_bad       <= '0;
            r_pix       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= '0;
                r_min[i] <= '0;
                r_max[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_good      <= n_good;
            r_bad       <= n_bad;
            r_pix       <= n_pix;
            r_out_valid <= n_out_valid;
            r_sum       <= n_sum;
            r_min       <= n_min;
            r_max       <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mean     <= n_mean;
        r_sci      <= n_sci;
        r_err      <= n_err;
        r_last     <= n_last;
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    `MPS_ASSERT_IMPL(a_done_state, i_clk, i_rst_n, i_div_done, (r_state == S_SNR) || (r_state == S_MWAIT))
    `MPS_ASSERT_IMPL(a_good_le_pix, i_clk, i_rst_n, 1'b1, r_good <= r_pix)
    `MPS_ASSERT_NEXT(a_load_clears, i_clk, i_rst_n, (r_state == S_OUT) && (!r_out_valid || i_m_tready), (r_good == '0) && (r_pix == '0) && r_out_valid)
endmodule
`default_nettype wire

>>> rtl/core/masked_pixel_statistics_core.sv
// top level of the masked pixel statistics core: front, shared divider, back
// depends on mps_pkg, mps_front, mps_divider, mps_back
//
// channel  dir  handshake                   payload
// s        in   i_s_tvalid / o_s_tready     i_s_tdata sci, err, flags; i_s_tlast last pixel
// m        out  o_m_tvalid / i_m_tready     o_m_tdata frame statistics and status
// cfg      in   i_cfg_valid / o_cfg_ready   i_cfg_data serious flag mask
//
// pixel that is flagged, bad-error or used with zero s/n: taken in S_IDLE as it is popped, without the divider
// pixel with positive error: s/n from the one-bit-per-cycle divider while the back part waits in S_SNR
// frame end: the three means in turn on the same divider (S_MSTART, S_MWAIT), skipped if no pixel is good
// front queue of 4 words keeps accepting while the back part divides, until the queue is full
// result register lets the next frame start while a result waits; no clearing pass
`default_nettype none
module masked_pixel_statistics_core #(
    parameter int MAX_PIXELS_LOG2 = mps_pkg::MAX_PIXELS_LOG2_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [15:0]          i_cfg_data,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [79:0]          i_s_tdata,  // sci_value, err_value, quality_flags
    input  wire logic                 i_s_tlast,  // last_pixel
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // good_count, sci_min, sci_max, sci_mean, err_min, err_max, err_mean,
    // snr_min, snr_max, snr_mean, frame_status
    output logic [(((MAX_PIXELS_LOG2 + 291) + 7) / 8) * 8 - 1:0] o_m_tdata
);
    localparam int CNT_W = MAX_PIXELS_LOG2 + 1;
    localparam int SUM_W = 32 + MAX_PIXELS_LOG2;
    localparam int DW    = (SUM_W > 48) ? SUM_W : 48;
    localparam int VW    = (CNT_W > 32) ? CNT_W : 32;
    localparam int OUT_W = (((CNT_W + 290) + 7) / 8) * 8;

    logic               q_valid, q_pop;
    mps_pkg::t_pix      q_item;
    logic               div_start, div_done;
    logic signed [DW-1:0] div_dividend;
    logic [VW-1:0]      div_divisor;
    logic signed [31:0] div_quot;

    mps_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_q_valid   (q_valid),
        .o_q_item    (q_item),
        .i_q_pop     (q_pop)
    );

    mps_divider #(.DW(DW), .VW(VW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    mps_back #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W),
        .DW    (DW),
        .VW    (VW),
        .OUT_W (OUT_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .o_div_start    (div_start),
        .o_div_dividend (div_dividend),
        .o_div_divisor  (div_divisor),
        .i_div_done     (div_done),
        .i_div_quot     (div_quot),
        .o_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .o_m_tdata      (o_m_tdata)
    );
endmodule
`default_nettype wire

>>> tb/masked_pixel_statistics_core_tb.sv
// testbench for masked_pixel_statistics_core: directed and random pixel frames
// with random stalls on both streams, checked against an in-bench predictor
// depends on mps_pkg and the core rtl
`default_nettype none
module masked_pixel_statistics_core_tb;

    localparam int LOG2 = 24;
    localparam int OW = (((LOG2 + 291) + 7) / 8) * 8;
    localparam int DRAIN = 400;

    typedef struct {
        logic [LOG2:0]      count;
        logic signed [31:0] mins[3];
        logic signed [31:0] maxs[3];
        logic signed [31:0] means[3];
        logic [1:0]         status;
    } t_stats;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic [15:0]     i_cfg_data = '0;
    logic            i_s_tvalid = 1'b0;
    logic            o_s_tready;
    logic [79:0]     i_s_tdata = '0;
    logic            i_s_tlast = 1'b0;
    logic            o_m_tvalid;
    logic            i_m_tready = 1'b0;
    logic [OW-1:0]   o_m_tdata;

    masked_pixel_statistics_core #(.MAX_PIXELS_LOG2(LOG2)) dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [15:0]        mask_copy;
    logic [LOG2:0]      good_n, bad_err_n, pix_n;
    logic [LOG2+31:0]   sums[3];
    logic signed [31:0] lo[3], hi[3];
    t_stats             pending_stats[$];

    int errors, pixels_sent, frames_seen;
    int rx_hold_request;
    bit no_idle;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch frame %0d %s: got %0h want %0h", frames_seen, what, got, want);
        errors++;
    endtask

    function automatic logic [LOG2:0] cnt_inc(input logic [LOG2:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    function automatic logic signed [31:0] sat32(input longint x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    task automatic clear_frame();
        good_n = '0; bad_err_n = '0; pix_n = '0;
        for (int k = 0; k < 3; k++) begin
            sums[k] = '0; lo[k] = '0; hi[k] = '0;
        end
    endtask

    task automatic predict_pixel(input logic signed [31:0] sci, input logic signed [31:0] err,
                                 input logic [15:0] flags, input logic last);
        logic signed [31:0] v[3];
        logic               used;
        t_stats             r;
        longint             s;
        v[0] = sci; v[1] = err; v[2] = '0;
        used = 1'b0;
        pix_n = cnt_inc(pix_n);
        if ((flags & mask_copy) == 16'h0) begin
            if (err <= 0) begin
                if (sci <= 0) used = 1'b1;
                else bad_err_n = cnt_inc(bad_err_n);
            end else begin
                used = 1'b1;
                v[2] = sat32((longint'(sci) * 65536) / longint'(err));
            end
        end
        if (used) begin
            for (int k = 0; k < 3; k++) begin
                if (good_n == 0) begin
                    lo[k] = v[k]; hi[k] = v[k]; sums[k] = '0;
                end else begin
                    if (v[k] < lo[k]) lo[k] = v[k];
                    if (v[k] > hi[k]) hi[k] = v[k];
                end
                sums[k] = sums[k] + {{(LOG2){v[k][31]}}, v[k]};
            end
            good_n = cnt_inc(good_n);
        end
        if (last) begin
            r.count = good_n;
            for (int k = 0; k < 3; k++) begin
                if (good_n != 0) begin
                    s = longint'(signed'(sums[k]));
                    r.mins[k] = lo[k]; r.maxs[k] = hi[k];
                    r.means[k] = sat32(s / longint'({1'b0, good_n}));
                end else begin
                    r.mins[k] = '0; r.maxs[k] = '0; r.means[k] = '0;
                end
            end
            if (good_n != 0) begin
                r.status = mps_pkg::ST_OK;
            end else if (bad_err_n != 0) begin
                r.status = (bad_err_n == pix_n) ? mps_pkg::ST_ALL_BAD : mps_pkg::ST_MIXED;
            end else begin
                r.status = mps_pkg::ST_FLAGGED;
            end
            pending_stats.push_back(r);
            clear_frame();
        end
    endtask

    // result checker
    initial begin
        t_stats w;
        logic [OW-1:0] d;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready) begin
                d = o_m_tdata;
                if (pending_stats.size() == 0) begin
                    report("unexpected result word", longint'(d[LOG2:0]), 0);
                end else begin
                    w = pending_stats.pop_front();
                    if (d[LOG2:0] !== w.count) report("good_count", d[LOG2:0], w.count);
                    for (int k = 0; k < 3; k++) begin
                        if (d[LOG2+1+96*k +: 32] !== w.mins[k])
                            report($sformatf("min%0d", k), d[LOG2+1+96*k +: 32], w.mins[k]);
                        if (d[LOG2+33+96*k +: 32] !== w.maxs[k])
                            report($sformatf("max%0d", k), d[LOG2+33+96*k +: 32], w.maxs[k]);
                        if (d[LOG2+65+96*k +: 32] !== w.means[k])
                            report($sformatf("mean%0d", k), d[LOG2+65+96*k +: 32], w.means[k]);
                    end
                    if (d[LOG2+289 +: 2] !== w.status)
                        report("frame_status", d[LOG2+289 +: 2], w.status);
                end
                frames_seen++;
            end
        end
    end

    // result ready driver with random stalls and an optional long hold
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold_request > 0) begin
                n = rx_hold_request;
                rx_hold_request = 0;
            end else begin
                n = no_idle ? 0 : $urandom_range(0, 15);
            end
            if (n > 0) begin
                i_m_tready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    task automatic send_pixel(input logic [31:0] sci, input logic [31:0] err,
                              input logic [15:0] flags, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {flags, err, sci};
        i_s_tlast <= last;
        do @(posedge i_clk); while (!o_s_tready);
        predict_pixel(sci, err, flags, last);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_stats.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    task automatic write_mask(input logic [15:0] m);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        mask_copy = m;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return $urandom_range(0, 8) - 4;
            4: return $urandom_range(0, 32'h000fffff) - 32'h00080000;
            5: return 32'h00010000;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_extremes();
        write_mask(16'h0000);
        send_pixel(32'h7fffffff, 32'h00000001, 16'hffff, 1'b0);
        send_pixel(32'h80000000, 32'h7fffffff, 16'h0000, 1'b0);
        send_pixel(32'h80000000, 32'h00000001, 16'h0000, 1'b0);
        send_pixel(32'h00000000, 32'h80000000, 16'h0000, 1'b1);
        send_pixel(32'h00010000, 32'h00010000, 16'h0001, 1'b1);
    endtask

    task automatic test_status_codes();
        write_mask(16'hffff);
        // every pixel flagged
        send_pixel(32'h00020000, 32'h00010000, 16'h8000, 1'b0);
        send_pixel(32'hfff00000, 32'h00010000, 16'h0001, 1'b1);
        // flags clear but bad error
        send_pixel(32'h00020000, 32'h00000000, 16'h0000, 1'b0);
        send_pixel(32'h00000001, 32'hffff0000, 16'h0000, 1'b1);
        // bad error mixed with flagged
        send_pixel(32'h00020000, 32'hffffffff, 16'h0000, 1'b0);
        send_pixel(32'h00020000, 32'h00010000, 16'h0100, 1'b1);
        // used with zero s/n, plus saturating s/n
        send_pixel(32'hffff0000, 32'h00000000, 16'h0000, 1'b0);
        send_pixel(32'h00000000, 32'hffffffff, 16'h0000, 1'b0);
        send_pixel(32'h7fffffff, 32'h00000001, 16'h0000, 1'b0);
        send_pixel(32'h80000000, 32'h00000001, 16'h0000, 1'b1);
    endtask

    task automatic random_frames(input int n_items, input logic [15:0] m);
        int left, len;
        logic [15:0] f;
        write_mask(m);
        left = n_items;
        while (left > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
                f = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom) & ~m;
                send_pixel(rand_q(), rand_q(), f, i == len - 1);
            end
            left -= len;
        end
    endtask

    task automatic test_backpressure();
        rx_hold_request = 600;
        no_idle = 1'b1;
        for (int fr = 0; fr < 6; fr++)
            for (int i = 0; i < 4; i++)
                send_pixel(rand_q(), rand_q(), 16'($urandom), i == 3);
        no_idle = 1'b0;
    endtask

    initial begin
        errors = 0; pixels_sent = 0; frames_seen = 0;
        rx_hold_request = 0; no_idle = 1'b0;
        mask_copy = '0;
        clear_frame();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_extremes();
        test_status_codes();
        random_frames(400, 16'h0000);
        random_frames(400, 16'h00ff);
        test_backpressure();
        no_idle = 1'b1;
        random_frames(200, 16'h8421);
        no_idle = 1'b0;
        random_frames(300, 16'hffff);
        random_frames(300, 16'($urandom));
        drain_results();
        $display("sent %0d pixels, checked %0d frame results", pixels_sent, frames_seen);
        $display("masks covered zero, full and random; status codes and s/n saturation hit");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("timeout");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
+incdir+rtl/core
rtl/core/mps_pkg.sv
rtl/core/mps_front.sv
rtl/core/mps_divider.sv
rtl/core/mps_back.sv
rtl/core/masked_pixel_statistics_core.sv
tb/masked_pixel_statistics_core_tb.sv
